@@ sv/rcls_pkg.sv @@
// Package with the shared types, codes and constants of the line sensor position block.
package rcls_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int TICK_W       = 16;
   localparam int POS_W        = 7;
   localparam int COUNT_W      = 4;
   localparam int SUM_W        = 8;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_TRACK  = 1'd1;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

   localparam logic signed [POS_W-1:0] POS_LOST_RIGHT = 7'sd45;
   localparam logic signed [POS_W-1:0] POS_LOST_LEFT  = -7'sd45;
   localparam logic signed [POS_W-1:0] POS_HIGH_LIMIT = 7'sd10;
   localparam logic signed [POS_W-1:0] POS_LOW_LIMIT  = -7'sd10;

   // Division runs one quotient bit per cycle over the magnitude of the sum.
   localparam int DIV_STEPS = POS_W;
   localparam int STEP_W    = 3;

   localparam logic signed [POS_W-1:0] WEIGHTS [SENSOR_COUNT] = '{
      -7'sd35, -7'sd20, -7'sd15, -7'sd8, 7'sd8, 7'sd15, 7'sd20, 7'sd35
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_SEND
   } rcls_state_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic div_step;
   } rcls_cmd_type;

   typedef struct packed {
      logic finish;
      logic lost;
      logic div_done;
   } rcls_status_type;

endpackage

@@ sv/rcls_if.sv @@
// Handshake interfaces for the request and result channels.
interface rcls_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] pin_levels;

   modport source (output valid, output action, output pin_levels, input ready);
   modport sink   (input valid, input action, input pin_levels, output ready);
endinterface

interface rcls_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [6:0] position;
   logic [3:0]        dark_count;
   logic [7:0]        line_bits;
   logic              line_lost;

   modport source (output valid, output position, output dark_count, output line_bits,
                   output line_lost, input ready);
   modport sink   (input valid, input position, input dark_count, input line_bits,
                   input line_lost, output ready);
endinterface

@@ sv/rcls_control.sv @@
// Controller state machine that sequences sampling, setup, division and result transfer.
module rcls_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rcls_pkg::rcls_status_type status,
   output rcls_pkg::rcls_cmd_type    cmd
);

   rcls_pkg::rcls_state_type state_ff;
   rcls_pkg::rcls_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcls_pkg::ST_IDLE: begin
            if (req_valid && status.finish) begin
               state_in = rcls_pkg::ST_SETUP;
            end
         end
         rcls_pkg::ST_SETUP: begin
            if (status.lost) begin
               state_in = rcls_pkg::ST_SEND;
            end else begin
               state_in = rcls_pkg::ST_DIVIDE;
            end
         end
         rcls_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = rcls_pkg::ST_SEND;
            end
         end
         rcls_pkg::ST_SEND: begin
            if (rsp_ready) begin
               if (req_valid && status.finish) begin
                  state_in = rcls_pkg::ST_SETUP;
               end else begin
                  state_in = rcls_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rcls_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.setup    = 1'b0;
      cmd.div_step = 1'b0;
      case (state_ff)
         rcls_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         rcls_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         rcls_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         rcls_pkg::ST_SEND: begin
            rsp_valid  = 1'b1;
            req_ready  = rsp_ready || !status.finish;
            cmd.accept = req_valid && (rsp_ready || !status.finish);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/rcls_datapath.sv @@
// Datapath with the scan state, settings registers, weighted sum and serial divider.
module rcls_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rcls_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rcls_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  rcls_pkg::rcls_cmd_type                 cmd,
   output rcls_pkg::rcls_status_type              status,
   input  logic                                   req_action,
   input  logic [rcls_pkg::SENSOR_COUNT-1:0]      req_pin_levels,
   output logic signed [rcls_pkg::POS_W-1:0]      rsp_position,
   output logic [rcls_pkg::COUNT_W-1:0]           rsp_dark_count,
   output logic [rcls_pkg::SENSOR_COUNT-1:0]      rsp_line_bits,
   output logic                                   rsp_line_lost
);

   localparam int N = rcls_pkg::SENSOR_COUNT;

   logic [rcls_pkg::TICK_W-1:0]       timeout_ff;
   logic                              invert_ff;
   logic [rcls_pkg::TICK_W-1:0]       tick_ff;
   logic [N-1:0]                      pending_ff;
   logic [N-1:0]                      dark_ff;
   logic                              scanning_ff;
   logic signed [rcls_pkg::POS_W-1:0] last_pos_ff;
   logic signed [rcls_pkg::POS_W-1:0] pos_ff;
   logic [N-1:0]                      line_ff;
   logic [rcls_pkg::COUNT_W-1:0]      count_ff;
   logic                              neg_ff;
   logic [rcls_pkg::POS_W-1:0]        quo_ff;
   logic [rcls_pkg::COUNT_W-1:0]      rem_ff;
   logic [rcls_pkg::STEP_W-1:0]       step_ff;

   logic                              sample;
   logic [N-1:0]                      discharged;
   logic [N-1:0]                      pending_upd;
   logic [N-1:0]                      dark_upd;
   logic [rcls_pkg::TICK_W-1:0]       tick_upd;
   logic                              scan_tick;
   logic                              finish_now;
   logic                              lost_now;
   logic                              div_done_now;

   logic [N-1:0]                      line;
   logic signed [rcls_pkg::SUM_W-1:0] sum;
   logic [rcls_pkg::COUNT_W-1:0]      count;
   logic signed [rcls_pkg::SUM_W-1:0] sum_abs;
   logic signed [rcls_pkg::POS_W-1:0] lost_pos;

   logic [rcls_pkg::COUNT_W:0]        trial;
   logic [rcls_pkg::COUNT_W:0]        trial_diff;
   logic                              trial_fits;
   logic [rcls_pkg::COUNT_W-1:0]      rem_in;
   logic [rcls_pkg::POS_W-1:0]        quo_in;
   logic signed [rcls_pkg::POS_W-1:0] div_pos;

   // Sampling of one tick against the running scan.
   always_comb begin
      scan_tick   = (req_action == rcls_pkg::ACTION_TICK) && scanning_ff;
      sample      = (pending_ff != '0) && (tick_ff < timeout_ff);
      discharged  = pending_ff & ~req_pin_levels;
      pending_upd = sample ? (pending_ff & ~discharged) : pending_ff;
      dark_upd    = sample ? (dark_ff & ~discharged) : dark_ff;
      tick_upd    = (sample && (tick_ff != rcls_pkg::TICK_MAX)) ? tick_ff + 1'b1 : tick_ff;
      finish_now  = scan_tick && ((pending_upd == '0) || (tick_upd >= timeout_ff));
   end

   // Weighted sum and count of the sensors on the line.
   always_comb begin
      line  = dark_ff ^ {N{invert_ff}};
      sum   = '0;
      count = '0;
      for (int i = 0; i < N; i++) begin
         if (line[i]) begin
            sum   = sum + rcls_pkg::SUM_W'(rcls_pkg::WEIGHTS[i]);
            count = count + 1'b1;
         end
      end
      sum_abs = (sum < 0) ? -sum : sum;
      if (last_pos_ff > rcls_pkg::POS_HIGH_LIMIT) begin
         lost_pos = rcls_pkg::POS_LOST_RIGHT;
      end else if (last_pos_ff < rcls_pkg::POS_LOW_LIMIT) begin
         lost_pos = rcls_pkg::POS_LOST_LEFT;
      end else begin
         lost_pos = '0;
      end
      lost_now = (count == '0);
   end

   // One restoring division step per cycle.
   always_comb begin
      trial        = {rem_ff, quo_ff[rcls_pkg::POS_W-1]};
      trial_fits   = (trial >= {1'b0, count_ff});
      trial_diff   = trial - {1'b0, count_ff};
      rem_in       = trial_fits ? trial_diff[rcls_pkg::COUNT_W-1:0]
                                : trial[rcls_pkg::COUNT_W-1:0];
      quo_in       = {quo_ff[rcls_pkg::POS_W-2:0], trial_fits};
      div_pos      = neg_ff ? -$signed(quo_in) : $signed(quo_in);
      div_done_now = (step_ff == '0);
   end

   always_comb begin
      status.finish   = finish_now;
      status.lost     = lost_now;
      status.div_done = div_done_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= rcls_pkg::TIMEOUT_RESET;
         invert_ff   <= 1'b0;
         tick_ff     <= '0;
         pending_ff  <= '0;
         dark_ff     <= '1;
         scanning_ff <= 1'b0;
         last_pos_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rcls_pkg::CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
               rcls_pkg::CSR_INVERT_TRACK:  invert_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            if (req_action == rcls_pkg::ACTION_START) begin
               tick_ff     <= '0;
               pending_ff  <= '1;
               dark_ff     <= '1;
               scanning_ff <= 1'b1;
            end else if (scanning_ff) begin
               tick_ff <= tick_upd;
               dark_ff <= dark_upd;
               if (finish_now) begin
                  pending_ff  <= '0;
                  scanning_ff <= 1'b0;
               end else begin
                  pending_ff <= pending_upd;
               end
            end
         end
         if (cmd.setup && lost_now) begin
            last_pos_ff <= lost_pos;
         end
         if (cmd.div_step && div_done_now) begin
            last_pos_ff <= div_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         line_ff  <= line;
         count_ff <= count;
         neg_ff   <= (sum < 0);
         quo_ff   <= sum_abs[rcls_pkg::POS_W-1:0];
         rem_ff   <= '0;
         step_ff  <= rcls_pkg::STEP_W'(rcls_pkg::DIV_STEPS - 1);
         if (lost_now) begin
            pos_ff <= lost_pos;
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff - 1'b1;
         if (div_done_now) begin
            pos_ff <= div_pos;
         end
      end
   end

   assign rsp_position   = pos_ff;
   assign rsp_dark_count = count_ff;
   assign rsp_line_bits  = line_ff;
   assign rsp_line_lost  = (count_ff == '0);

endmodule

@@ sv/rc_line_sensor_position.sv @@
// Top level of the RC reflectance line sensor position block.
// The request channel carries start items (action 0) and timer ticks with the
// eight pin levels (action 1). A start item clears the scan; each tick samples
// the pins of the sensors that are still charged. When every sensor has
// discharged or the timeout is reached, one result is sent on the response
// channel with the weighted position, the dark count and the line bits.
// Items that do not end a scan are accepted back to back. After the tick that
// ends a scan, the block runs a setup state and then, when some sensor is on
// the line, the serial divider, which produces one quotient bit per cycle;
// with no sensor on the line it sends the result after setup. No request is
// accepted in between. While the result waits for the receiver, requests
// still flow, but a tick that would end the next scan is held until the
// result transfer completes, so a stalled receiver holds back only that tick.
// The settings port sets the timeout (index 0) and track inversion (index 1);
// the user must write it only while the block is idle; nothing enforces this.
// Reset is synchronous and active high: it sets the timeout to 500 ticks,
// clears inversion, stops any scan and clears the held position.
module rc_line_sensor_position (
   input  logic                                clock,
   input  logic                                reset,
   rcls_req_if.sink                            req_ch,
   rcls_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [rcls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcls_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rcls_pkg::rcls_cmd_type    cmd;
   rcls_pkg::rcls_status_type status;

   rcls_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcls_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_ch.action),
      .req_pin_levels (req_ch.pin_levels),
      .rsp_position   (rsp_ch.position),
      .rsp_dark_count (rsp_ch.dark_count),
      .rsp_line_bits  (rsp_ch.line_bits),
      .rsp_line_lost  (rsp_ch.line_lost)
   );

endmodule
